FILE: hdl/radiomap_level_scorer_defines.svh
// assertion macros for the level scorer
`ifndef RADIOMAP_LEVEL_SCORER_DEFINES_SVH
`define RADIOMAP_LEVEL_SCORER_DEFINES_SVH
// check a property on every clock edge outside reset
`define RLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check a property on every clock edge, reset included
`define RLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hdl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// shared types, codes and arithmetic helpers of the level scorer
// ----------------------------------------------------------------------------
`default_nettype none
package rls_pkg;
  localparam int unsigned WeightW = 40;
  localparam int unsigned CountW = 7;
  localparam int unsigned MagW = 12;
  localparam int unsigned TxW = 16;
  localparam int unsigned LvlW = 4;
  localparam int unsigned TermW = 20;
  localparam int unsigned SumW = 36;
  localparam logic [WeightW-1:0] WeightMax = {WeightW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [TermW+4:0] TermNum = 25'd10485760;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_SCAN = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic [LvlW-1:0] lvl;
    logic [TxW-1:0] tx;
    logic [MagW-1:0] mag;
    logic last;
  } item_t;

  function automatic logic [MagW-1:0] magnitude(input logic [MagW-1:0] raw);
    logic [MagW-1:0] r;
    r = raw[MagW-1] ? (~raw + 1'b1) : raw;
    if (raw == {1'b1, {(MagW-1){1'b0}}}) r = {1'b1, {(MagW-1){1'b0}}};
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/rls_divider.sv
// ----------------------------------------------------------------------------
// rls_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rls_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [35:0] num,
  input  wire logic [35:0] den,
  output logic             done,
  output logic [35:0]      quo
);
  import rls_pkg::*;
  logic [35:0] rem;
  logic [35:0] n;
  logic [35:0] d;
  logic [5:0]  cnt;
  logic        run;
  logic [36:0] trial;

  assign trial = {rem, n[35]} - {1'b0, d};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      run <= 1'b1;
      n <= num;
      d <= den;
      rem <= '0;
      cnt <= 6'd36;
    end else if (run) begin
      if (!trial[36]) begin
        rem <= trial[35:0];
        n <= {n[34:0], 1'b1};
      end else begin
        rem <= {rem[34:0], n[35]};
        n <= {n[34:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign quo = n;
endmodule
`default_nettype wire

FILE: hdl/rls_front.sv
// ----------------------------------------------------------------------------
// rls_front
// command intake and two-deep queue toward the scoring engine
// ----------------------------------------------------------------------------
`default_nettype none
module rls_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rls_pkg::item_t  din,
  output logic                 full,
  output logic                 avail,
  output rls_pkg::item_t       dout,
  input  wire logic            pop
);
  import rls_pkg::*;
  item_t q [2];
  item_t din_m;
  logic [1:0] fill;
  logic rd;
  logic wr;

  assign full = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign dout = q[rd];

  always_comb begin
    din_m = din;
    din_m.mag = magnitude(din.mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      rd <= 1'b0;
      wr <= 1'b0;
    end else begin
      if (push && !full) begin
        q[wr] <= din_m;
        wr <= ~wr;
      end
      if (pop && avail) rd <= ~rd;
      fill <= fill + {1'b0, push && !full} - {1'b0, pop && avail};
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rls_back.sv
// ----------------------------------------------------------------------------
// rls_back
// radiomap store, per-level scoring walk and final selection
// ----------------------------------------------------------------------------
`default_nettype none
`include "radiomap_level_scorer_defines.svh"
module rls_back #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           avail,
  input  wire rls_pkg::item_t item,
  output logic                pop,
  output logic                idle,
  output logic                res_valid,
  output logic [3:0]          res_level,
  output logic                res_found,
  output logic [39:0]         res_weight
);
  import rls_pkg::*;
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LCW = $clog2(MAX_LEVELS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_TERM, S_TDIV, S_MEAN, S_MDIV, S_NEXTL,
    S_PMUL0, S_PMUL1, S_PCMP
  } state_t;

  state_t state;
  logic [LvlW+TxW+MagW-1:0] mem [MAX_ENTRIES];
  logic [LvlW+TxW+MagW-1:0] rdata;
  logic [EW-1:0] entry_count;
  logic [EW-1:0] eidx;
  logic [LCW-1:0] lvl;
  item_t cur;
  logic [WeightW-1:0] wsum [MAX_LEVELS];
  logic [CountW-1:0] mcnt [MAX_LEVELS];
  logic [SumW-1:0] tsum;
  logic [EW-1:0] hits;
  logic [MagW-1:0] diff;
  logic div_go;
  logic [35:0] div_num;
  logic [35:0] div_den;
  logic div_done;
  logic [35:0] div_quo;
  logic [WeightW:0] wadd;
  logic [WeightW+CountW-1:0] prod;
  logic [WeightW-1:0] prod_sat;
  logic [LW-1:0] li;
  logic [WeightW-1:0] best_w;
  logic [LvlW-1:0] best_l;
  logic best_f;
  logic [LvlW-1:0] em_lvl;
  logic [TxW-1:0] em_tx;
  logic [MagW-1:0] em_mag;

  assign li = lvl[LW-1:0];
  assign {em_lvl, em_tx, em_mag} = rdata;
  assign idle = (state == S_IDLE);
  assign pop = idle && avail;
  assign wadd = {1'b0, wsum[li]} + {5'b0, div_quo};
  assign prod_sat = (prod[WeightW+CountW-1:WeightW] != '0) ? WeightMax : prod[WeightW-1:0];

  rls_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    rdata <= mem[eidx[AW-1:0]];
    if (pop && item.cmd == CMD_LOAD && entry_count < EW'(MAX_ENTRIES)
        && {28'b0, item.lvl} < 32'(MAX_LEVELS))
      mem[entry_count[AW-1:0]] <= {item.lvl, item.tx, item.mag};
  end

  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    res_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        wsum[i] <= '0;
        mcnt[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= item;
            unique case (item.cmd)
              CMD_CLEAR: entry_count <= '0;
              CMD_LOAD: begin
                if (entry_count < EW'(MAX_ENTRIES) && {28'b0, item.lvl} < 32'(MAX_LEVELS))
                  entry_count <= entry_count + 1'b1;
              end
              CMD_SCAN: begin
                lvl <= '0;
                eidx <= '0;
                tsum <= '0;
                hits <= '0;
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (eidx == entry_count) state <= S_MEAN;
          else state <= S_WAIT;
        end
        S_WAIT: state <= S_TERM;
        S_TERM: begin
          diff <= (cur.mag > em_mag) ? cur.mag - em_mag : em_mag - cur.mag;
          if ({28'b0, em_lvl} == 32'(lvl) && em_tx == cur.tx) begin
            state <= S_TDIV;
            div_go <= 1'b1;
          end else begin
            eidx <= eidx + 1'b1;
            state <= S_RD;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            tsum <= tsum + div_quo;
            hits <= hits + 1'b1;
            eidx <= eidx + 1'b1;
            state <= S_RD;
          end
        end
        S_MEAN: begin
          if (hits == '0) state <= S_NEXTL;
          else begin
            div_go <= 1'b1;
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            wsum[li] <= wadd[WeightW] ? WeightMax : wadd[WeightW-1:0];
            if (mcnt[li] != CountMax) mcnt[li] <= mcnt[li] + 1'b1;
            state <= S_NEXTL;
          end
        end
        S_NEXTL: begin
          eidx <= '0;
          tsum <= '0;
          hits <= '0;
          if (lvl == LCW'(MAX_LEVELS - 1)) begin
            lvl <= '0;
            best_w <= '0;
            best_l <= '0;
            best_f <= 1'b0;
            state <= cur.last ? S_PMUL0 : S_IDLE;
          end else begin
            lvl <= lvl + 1'b1;
            state <= S_RD;
          end
        end
        S_PMUL0: begin
          prod <= wsum[li] * mcnt[li];
          state <= S_PMUL1;
        end
        S_PMUL1: state <= S_PCMP;
        S_PCMP: begin
          if (prod_sat > best_w) begin
            best_w <= prod_sat;
            best_l <= LvlW'(lvl);
            best_f <= 1'b1;
          end
          if (lvl == LCW'(MAX_LEVELS - 1)) begin
            res_valid <= 1'b1;
            res_level <= (prod_sat > best_w) ? LvlW'(lvl) : best_l;
            res_found <= (prod_sat > best_w) | best_f;
            res_weight <= (prod_sat > best_w) ? prod_sat : best_w;
            for (int i = 0; i < MAX_LEVELS; i++) begin
              wsum[i] <= '0;
              mcnt[i] <= '0;
            end
            state <= S_IDLE;
          end else begin
            lvl <= lvl + 1'b1;
            state <= S_PMUL0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the divider samples its operands in the same cycle as go
  always_comb begin
    div_den = 36'd0;
    div_num = 36'd0;
    if (state == S_MDIV) begin
      div_num = tsum;
      div_den = 36'(hits);
    end else begin
      div_num = 36'(TermNum);
      div_den = 36'({diff, 3'b0}) + 36'({diff, 1'b0}) + 36'd16;
    end
  end

  `RLS_ASSERT(a_count_bound, entry_count <= EW'(MAX_ENTRIES), "entry count overflow")
  `RLS_ASSERT(a_res_scan, res_valid |-> $past(state) == S_PCMP, "result outside selection")
  `RLS_ASSERT(a_found_w, res_valid |-> (res_found == (res_weight != '0)), "found flag mismatch")
endmodule
`default_nettype wire

FILE: hdl/radiomap_level_scorer.sv
// ----------------------------------------------------------------------------
// radiomap_level_scorer
// fingerprint radiomap level estimation: load, clear and scan commands
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// command   in   start / busy         command entry_level transmitter signal last_measurement
// result    out  strobe (one cycle)   best_level level_found best_weight
//
// load and clear are handled in the engine's idle state without leaving it
// a scan walks all entries once per level, reading, waiting on and matching each entry,
// and uses the shared divider once per match and once per matching level
// a last measurement adds a multiply and a compare step per level for the products
// reset clears the entry count and scan sums; the radiomap needs no clearing
// busy rises when the two-entry queue is full
`default_nettype none
module radiomap_level_scorer #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic [3:0]         entry_level,
  input  wire logic [15:0]        transmitter,
  input  wire logic signed [11:0] signal,
  input  wire logic               last_measurement,
  output logic                    strobe,
  output logic [3:0]              best_level,
  output logic                    level_found,
  output logic [39:0]             best_weight
);
  import rls_pkg::*;
  item_t din;
  item_t q_item;
  logic full;
  logic avail;
  logic pop;
  logic idle;

  assign din = '{cmd: cmd_t'(command), lvl: entry_level, tx: transmitter,
                 mag: signal, last: last_measurement};
  assign busy = full;

  rls_front u_front (
    .clk(clk), .rst(rst), .push(start), .din(din), .full(full),
    .avail(avail), .dout(q_item), .pop(pop)
  );

  rls_back #(.MAX_LEVELS(MAX_LEVELS), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .item(q_item), .pop(pop), .idle(idle),
    .res_valid(strobe), .res_level(best_level), .res_found(level_found),
    .res_weight(best_weight)
  );

  logic unused_idle;
  assign unused_idle = idle;
endmodule
`default_nettype wire
